// ===== design/cns_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cns_pkg
// shared types, codes, coefficient table and microprogram of the noise shaper
// ----------------------------------------------------------------------------
package cns_pkg;

    // coefficient format q1.24
    localparam int COEF_W    = 25;
    localparam int COEF_FRAC = 24;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 15;
    localparam int HALF_COEF = 1 << (COEF_FRAC - 1);
    localparam int HALF_GAIN = 1 << (GAIN_FRAC - 1);
    localparam logic [GAIN_W:0] GAIN_ONE = 17'd32768;

    // request commands
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_TRIGGER = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    // noise modes
    localparam logic [1:0] MODE_WHITE = 2'd0;
    localparam logic [1:0] MODE_PINK  = 2'd1;
    localparam logic [1:0] MODE_BROWN = 2'd2;

    typedef logic [4:0] step_t;

    // entry points of the microprogram
    localparam step_t A_DISPATCH = 5'd0;
    localparam step_t A_PINK     = 5'd1;
    localparam step_t A_GAIN     = 5'd17;
    localparam step_t A_RESULT   = 5'd18;
    localparam step_t A_BROWN    = 5'd19;
    localparam step_t A_ZERO     = 5'd21;

    typedef enum logic [2:0] {
        K_POLE,
        K_FEED,
        K_DIRECT,
        K_DELAY,
        K_SCALE,
        K_BROWN,
        K_GAIN
    } coef_kind_t;

    typedef enum logic [1:0] {
        B_WHITE,
        B_SECTION,
        B_ACC,
        B_NOISE
    } bsel_t;

    typedef enum logic [3:0] {
        WB_NONE,
        WB_TEMP,
        WB_SECTION,
        WB_ACC_ADD,
        WB_DELAY,
        WB_NOISE,
        WB_BROWN,
        WB_RESULT,
        WB_ZERO
    } wb_t;

    typedef enum logic [1:0] {
        J_NEXT,
        J_GOTO,
        J_MODE,
        J_END
    } jmp_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef struct packed {
        logic       mul_en;
        coef_kind_t coef;
        bsel_t      bsel;
        logic [2:0] mul_idx;
        wb_t        wb;
        logic [2:0] wb_idx;
        jmp_t       jmp;
        step_t      target;
    } ucode_t;

    // control bundle from sequencer to datapath
    typedef struct packed {
        logic       load;
        logic       mul_en;
        coef_kind_t coef;
        bsel_t      bsel;
        logic [2:0] mul_idx;
        wb_t        wb;
        logic [2:0] wb_idx;
        logic       out_we;
    } cns_ctrl_t;

    function automatic ucode_t uc(
        input logic       mul_en,
        input coef_kind_t coef,
        input bsel_t      bsel,
        input logic [2:0] mul_idx,
        input wb_t        wb,
        input logic [2:0] wb_idx,
        input jmp_t       jmp,
        input step_t      target
    );
        ucode_t u;
        u.mul_en  = mul_en;
        u.coef    = coef;
        u.bsel    = bsel;
        u.mul_idx = mul_idx;
        u.wb      = wb;
        u.wb_idx  = wb_idx;
        u.jmp     = jmp;
        u.target  = target;
        return u;
    endfunction

    // microprogram: the multiply issued in a step is written back in the next
    function automatic ucode_t ucode_rom(input step_t addr);
        ucode_t u;
        case (addr)
            5'd0:  u = uc(1'b0, K_GAIN,   B_WHITE,   3'd0, WB_NONE,    3'd0, J_MODE, A_DISPATCH);
            5'd1:  u = uc(1'b1, K_POLE,   B_SECTION, 3'd0, WB_NONE,    3'd0, J_NEXT, A_DISPATCH);
            5'd2:  u = uc(1'b1, K_FEED,   B_WHITE,   3'd0, WB_TEMP,    3'd0, J_NEXT, A_DISPATCH);
            5'd3:  u = uc(1'b1, K_POLE,   B_SECTION, 3'd1, WB_SECTION, 3'd0, J_NEXT, A_DISPATCH);
            5'd4:  u = uc(1'b1, K_FEED,   B_WHITE,   3'd1, WB_TEMP,    3'd0, J_NEXT, A_DISPATCH);
            5'd5:  u = uc(1'b1, K_POLE,   B_SECTION, 3'd2, WB_SECTION, 3'd1, J_NEXT, A_DISPATCH);
            5'd6:  u = uc(1'b1, K_FEED,   B_WHITE,   3'd2, WB_TEMP,    3'd0, J_NEXT, A_DISPATCH);
            5'd7:  u = uc(1'b1, K_POLE,   B_SECTION, 3'd3, WB_SECTION, 3'd2, J_NEXT, A_DISPATCH);
            5'd8:  u = uc(1'b1, K_FEED,   B_WHITE,   3'd3, WB_TEMP,    3'd0, J_NEXT, A_DISPATCH);
            5'd9:  u = uc(1'b1, K_POLE,   B_SECTION, 3'd4, WB_SECTION, 3'd3, J_NEXT, A_DISPATCH);
            5'd10: u = uc(1'b1, K_FEED,   B_WHITE,   3'd4, WB_TEMP,    3'd0, J_NEXT, A_DISPATCH);
            5'd11: u = uc(1'b1, K_POLE,   B_SECTION, 3'd5, WB_SECTION, 3'd4, J_NEXT, A_DISPATCH);
            5'd12: u = uc(1'b1, K_FEED,   B_WHITE,   3'd5, WB_TEMP,    3'd0, J_NEXT, A_DISPATCH);
            5'd13: u = uc(1'b1, K_DIRECT, B_WHITE,   3'd0, WB_SECTION, 3'd5, J_NEXT, A_DISPATCH);
            5'd14: u = uc(1'b1, K_DELAY,  B_WHITE,   3'd0, WB_ACC_ADD, 3'd0, J_NEXT, A_DISPATCH);
            5'd15: u = uc(1'b1, K_SCALE,  B_ACC,     3'd0, WB_DELAY,   3'd0, J_NEXT, A_DISPATCH);
            5'd16: u = uc(1'b0, K_GAIN,   B_WHITE,   3'd0, WB_NOISE,   3'd0, J_NEXT, A_DISPATCH);
            5'd17: u = uc(1'b1, K_GAIN,   B_NOISE,   3'd0, WB_NONE,    3'd0, J_NEXT, A_DISPATCH);
            5'd18: u = uc(1'b0, K_GAIN,   B_WHITE,   3'd0, WB_RESULT,  3'd0, J_END,  A_DISPATCH);
            5'd19: u = uc(1'b1, K_BROWN,  B_WHITE,   3'd0, WB_NONE,    3'd0, J_NEXT, A_DISPATCH);
            5'd20: u = uc(1'b0, K_GAIN,   B_WHITE,   3'd0, WB_BROWN,   3'd0, J_GOTO, A_GAIN);
            5'd21: u = uc(1'b0, K_GAIN,   B_WHITE,   3'd0, WB_ZERO,    3'd0, J_END,  A_DISPATCH);
            default: u = uc(1'b0, K_GAIN, B_WHITE,   3'd0, WB_NONE,    3'd0, J_END,  A_DISPATCH);
        endcase
        return u;
    endfunction

    // q1.24 coefficients of the refined pink filter and the brown step
    function automatic logic signed [COEF_W-1:0] coef_value(
        input coef_kind_t kind,
        input logic [2:0] idx
    );
        logic signed [COEF_W-1:0] c;
        case (kind)
            K_POLE: begin
                case (idx)
                    3'd0:    c = 25'sd16758090;
                    3'd1:    c = 25'sd16665144;
                    3'd2:    c = 25'sd16257122;
                    3'd3:    c = 25'sd14537458;
                    3'd4:    c = 25'sd9227469;
                    3'd5:    c = -25'sd12777528;
                    default: c = '0;
                endcase
            end
            K_FEED: begin
                case (idx)
                    3'd0:    c = 25'sd931436;
                    3'd1:    c = 25'sd1259565;
                    3'd2:    c = 25'sd2581208;
                    3'd3:    c = 25'sd5209084;
                    3'd4:    c = 25'sd8941454;
                    3'd5:    c = -25'sd283501;
                    default: c = '0;
                endcase
            end
            K_DIRECT: c = 25'sd8995943;
            K_DELAY:  c = 25'sd1944916;
            K_SCALE:  c = 25'sd1845494;
            K_BROWN:  c = 25'sd335544;
            default:  c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== design/colored_noise_shaper_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colored_noise_shaper_unit
// colors white noise (white, refined pink, brown) and scales it by a level
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  in       sink       in_valid/in_stall   command, white_sample
//  out      source     out_valid/out_stall noise_sample
//  cfg      apb slave  psel/penable/pready noise_mode @0x0, output_gain @0x4
//
//  trigger and release finish at acceptance; a tick runs the microprogram
//  on the pink, brown, white, unused mode or silent path, walking one
//  shared 25 x (SAMPLE_BITS+8) multiplier
//  reset clears config, play flag and all filter state; no clearing pass
//  a finished result sits in the output register, so a new request is taken
//  while it waits; the program holds on its last step only if the output
//  register is still full and stalled
// ----------------------------------------------------------------------------
module colored_noise_shaper_unit #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic signed [SAMPLE_BITS-1:0] white_sample,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] noise_sample,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_GAIN = 1'b1;

    logic [1:0]                    noise_mode_reg;
    logic [cns_pkg::GAIN_W-1:0]    output_gain_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] noise_sample_reg;
    logic                          cfg_write;
    logic                          out_free;
    logic signed [SAMPLE_BITS-1:0] dp_result;
    cns_pkg::cns_ctrl_t            ctrl;

    // register file, pready tied high
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_mode_reg  <= cns_pkg::MODE_WHITE;
            output_gain_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_MODE: noise_mode_reg  <= pwdata[1:0];
                REG_GAIN: output_gain_reg <= pwdata[cns_pkg::GAIN_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MODE: prdata = {30'd0, noise_mode_reg};
            REG_GAIN: prdata = {16'd0, output_gain_reg};
            default:  prdata = '0;
        endcase
    end

    // output register: free when empty or being taken this cycle
    assign out_free     = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign noise_sample = noise_sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.out_we)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_we)
            noise_sample_reg <= dp_result;
    end

    // control: step counter and microprogram
    cns_sequencer u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .noise_mode   (noise_mode_reg),
        .gain_nonzero (|output_gain_reg),
        .out_free     (out_free),
        .ctrl         (ctrl)
    );

    // arithmetic and filter state
    cns_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .white_sample (white_sample),
        .output_gain  (output_gain_reg),
        .result       (dp_result)
    );

endmodule

// ===== design/cns_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cns_datapath
// shared multiplier, rounding, saturation and filter state of the shaper
// ----------------------------------------------------------------------------
module cns_datapath #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cns_pkg::cns_ctrl_t            ctrl,
    input  logic signed [SAMPLE_BITS-1:0] white_sample,
    input  logic [cns_pkg::GAIN_W-1:0]    output_gain,
    output logic signed [SAMPLE_BITS-1:0] result
);

    localparam int SB = SAMPLE_BITS;
    localparam int WI = SB + 8;                  // q9.f internal width
    localparam int RW = WI + 1;                  // rounded product width
    localparam int AW = WI + 4;                  // pink sum accumulator
    localparam int PW = cns_pkg::COEF_W + WI;    // product width
    localparam int NSEC = 6;

    localparam logic signed [WI-1:0] IMAX = {1'b0, {(WI-1){1'b1}}};
    localparam logic signed [WI-1:0] IMIN = {1'b1, {(WI-1){1'b0}}};
    localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

    logic signed [SB-1:0] w_reg;
    logic signed [WI-1:0] sec_reg [NSEC];
    logic signed [SB-1:0] delay_reg;
    logic signed [SB-1:0] brown_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [RW-1:0] t_reg;
    logic signed [WI-1:0] noise_reg;
    logic signed [PW-1:0] p_reg;

    logic [cns_pkg::GAIN_W:0]         gain_clip;
    logic signed [cns_pkg::COEF_W-1:0] mul_a;
    logic signed [WI-1:0]              mul_b;
    logic signed [WI-1:0]              acc_sat;
    logic signed [PW-1:0]              prod;
    logic signed [PW-1:0]              rnd_sum;
    logic signed [RW-1:0]              wb_val;
    logic signed [RW:0]                sec_sum;
    logic signed [WI-1:0]              sec_new;
    logic signed [RW:0]                brown_sum;
    logic signed [SB-1:0]              brown_new;
    logic signed [SB-1:0]              res_sat;
    logic                              res_step;

    assign gain_clip = ({1'b0, output_gain} > cns_pkg::GAIN_ONE) ? cns_pkg::GAIN_ONE
                                                                 : {1'b0, output_gain};

    // pink sum clamped to q9.f before scaling
    always_comb
    begin
        if (&acc_reg[AW-1:WI-1] || ~|acc_reg[AW-1:WI-1])
            acc_sat = acc_reg[WI-1:0];
        else
            acc_sat = acc_reg[AW-1] ? IMIN : IMAX;
    end

    always_comb
    begin
        if (ctrl.coef == cns_pkg::K_GAIN)
            mul_a = $signed({{(cns_pkg::COEF_W - cns_pkg::GAIN_W - 1){1'b0}}, gain_clip});
        else
            mul_a = cns_pkg::coef_value(ctrl.coef, ctrl.mul_idx);
        case (ctrl.bsel)
            cns_pkg::B_WHITE:   mul_b = WI'(w_reg);
            cns_pkg::B_SECTION: mul_b = sec_reg[ctrl.mul_idx];
            cns_pkg::B_ACC:     mul_b = acc_sat;
            cns_pkg::B_NOISE:   mul_b = noise_reg;
            default:            mul_b = '0;
        endcase
    end

    assign prod = PW'(mul_a) * PW'(mul_b);

    // round half up, then floor shift by the format of the product
    assign res_step = (ctrl.wb == cns_pkg::WB_RESULT);
    assign rnd_sum  = p_reg + (res_step ? PW'(cns_pkg::HALF_GAIN) : PW'(cns_pkg::HALF_COEF));
    assign wb_val   = res_step ? $signed(rnd_sum[cns_pkg::GAIN_FRAC +: RW])
                               : $signed(rnd_sum[cns_pkg::COEF_FRAC +: RW]);

    always_comb
    begin
        sec_sum = (RW+1)'(t_reg) + (RW+1)'(wb_val);
        if (&sec_sum[RW:WI-1] || ~|sec_sum[RW:WI-1])
            sec_new = sec_sum[WI-1:0];
        else
            sec_new = sec_sum[RW] ? IMIN : IMAX;

        // brown level held in [-1, 1 - lsb]
        brown_sum = (RW+1)'(brown_reg) + (RW+1)'(wb_val);
        if (&brown_sum[RW:SB-1] || ~|brown_sum[RW:SB-1])
            brown_new = brown_sum[SB-1:0];
        else
            brown_new = brown_sum[RW] ? SMIN : SMAX;

        if (&wb_val[RW-1:SB-1] || ~|wb_val[RW-1:SB-1])
            res_sat = wb_val[SB-1:0];
        else
            res_sat = wb_val[RW-1] ? SMIN : SMAX;
    end

    assign result = (ctrl.wb == cns_pkg::WB_RESULT) ? res_sat : '0;

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NSEC; k++)
                sec_reg[k] <= '0;
            delay_reg <= '0;
            brown_reg <= '0;
        end
        else
        begin
            case (ctrl.wb)
                cns_pkg::WB_SECTION: sec_reg[ctrl.wb_idx] <= sec_new;
                cns_pkg::WB_DELAY:   delay_reg <= wb_val[SB-1:0];
                cns_pkg::WB_BROWN:   brown_reg <= brown_new;
                default:             ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
            p_reg <= prod;
        if (ctrl.load)
        begin
            w_reg     <= white_sample;
            noise_reg <= WI'(white_sample);
            acc_reg   <= AW'(delay_reg);
        end
        else
        begin
            case (ctrl.wb)
                cns_pkg::WB_TEMP:    t_reg <= wb_val;
                cns_pkg::WB_SECTION: acc_reg <= acc_reg + AW'(sec_new);
                cns_pkg::WB_ACC_ADD: acc_reg <= acc_reg + AW'(wb_val);
                cns_pkg::WB_NOISE:   noise_reg <= wb_val[WI-1:0];
                cns_pkg::WB_BROWN:   noise_reg <= WI'(brown_new);
                default:             ;
            endcase
        end
    end

endmodule

// ===== design/cns_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cns_sequencer
// step counter over the microprogram, command handling and play flag
// ----------------------------------------------------------------------------
module cns_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [1:0]         noise_mode,
    input  logic               gain_nonzero,
    input  logic               out_free,
    output cns_pkg::cns_ctrl_t ctrl
);

    cns_pkg::seq_state_t state_reg, state_next;
    cns_pkg::step_t      step_reg, step_next;
    logic                playing_reg, playing_next;
    cns_pkg::ucode_t     uw;
    logic                accept;
    logic                result_step;

    assign uw          = cns_pkg::ucode_rom(step_reg);
    assign in_stall    = (state_reg == cns_pkg::SEQ_RUN);
    assign accept      = in_valid && (state_reg == cns_pkg::SEQ_IDLE);
    assign result_step = (uw.wb == cns_pkg::WB_RESULT) || (uw.wb == cns_pkg::WB_ZERO);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cns_pkg::SEQ_IDLE;
            step_reg    <= cns_pkg::A_DISPATCH;
            playing_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            playing_reg <= playing_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        playing_next = playing_reg;
        ctrl         = '0;
        ctrl.coef    = cns_pkg::K_GAIN;
        ctrl.bsel    = cns_pkg::B_WHITE;
        ctrl.wb      = cns_pkg::WB_NONE;
        case (state_reg)
            cns_pkg::SEQ_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        cns_pkg::CMD_TICK:
                        begin
                            ctrl.load  = 1'b1;
                            state_next = cns_pkg::SEQ_RUN;
                            step_next  = (playing_reg && gain_nonzero) ? cns_pkg::A_DISPATCH
                                                                       : cns_pkg::A_ZERO;
                        end
                        cns_pkg::CMD_TRIGGER:
                        begin
                            if (gain_nonzero)
                                playing_next = 1'b1;
                        end
                        cns_pkg::CMD_RELEASE: playing_next = 1'b0;
                        default:              ;
                    endcase
                end
            end
            cns_pkg::SEQ_RUN:
            begin
                ctrl.mul_en  = uw.mul_en;
                ctrl.coef    = uw.coef;
                ctrl.bsel    = uw.bsel;
                ctrl.mul_idx = uw.mul_idx;
                ctrl.wb      = uw.wb;
                ctrl.wb_idx  = uw.wb_idx;
                ctrl.out_we  = result_step && out_free;
                case (uw.jmp)
                    cns_pkg::J_NEXT: step_next = step_reg + 5'd1;
                    cns_pkg::J_GOTO: step_next = uw.target;
                    cns_pkg::J_MODE:
                    begin
                        case (noise_mode)
                            cns_pkg::MODE_WHITE: step_next = cns_pkg::A_GAIN;
                            cns_pkg::MODE_PINK:  step_next = cns_pkg::A_PINK;
                            cns_pkg::MODE_BROWN: step_next = cns_pkg::A_BROWN;
                            default:             step_next = cns_pkg::A_ZERO;
                        endcase
                    end
                    cns_pkg::J_END:
                    begin
                        // hold on the last step until the output register frees
                        if (out_free)
                            state_next = cns_pkg::SEQ_IDLE;
                    end
                    default: state_next = cns_pkg::SEQ_IDLE;
                endcase
            end
            default: state_next = cns_pkg::SEQ_IDLE;
        endcase
    end

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cns_pkg::SEQ_RUN |-> step_reg <= cns_pkg::A_ZERO)
        else $error("step counter left the microprogram");

    a_quiet_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_we && !(playing_reg && gain_nonzero) |-> uw.wb == cns_pkg::WB_ZERO)
        else $error("silent tick ran the filter program");

    a_trigger_gain: assert property (@(posedge clk) disable iff (!rst_n)
        accept && command == cns_pkg::CMD_TRIGGER && !gain_nonzero
        |=> playing_reg == $past(playing_reg))
        else $error("trigger with zero level changed the play flag");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_we |=> state_reg == cns_pkg::SEQ_IDLE)
        else $error("sequencer kept running after its result");

endmodule

// ===== bench/colored_noise_shaper_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colored_noise_shaper_unit_tb
// self-checking bench for the white / pink / brown noise shaper
// ----------------------------------------------------------------------------
//  a scoreboard class keeps its own copy of the filter state and the two
//  configuration registers and predicts every tick result in 64-bit integer
//  arithmetic; a short directed part covers the silent, trigger and
//  saturation corners, then random phases change the mode and level over the
//  apb port and send trigger / tick / release streams with random idling on
//  both channels
// ----------------------------------------------------------------------------
module colored_noise_shaper_unit_tb;

    localparam int          SW            = 24;
    localparam logic [2:0]  ADDR_MODE     = 3'd0;
    localparam logic [2:0]  ADDR_GAIN     = 3'd4;
    localparam logic [1:0]  CMD_UNUSED    = 2'd3;
    localparam logic [1:0]  MODE_UNUSED   = 2'd3;
    localparam int          RANDOM_ITEMS  = 1200;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          CYCLE_LIMIT   = 600000;
    localparam logic signed [SW-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SW-1:0] SAMPLE_MIN = 24'sh800000;

    // ------------------------------------------------------------------------
    // scoreboard: predicts one noise sample per tick, checks results in order
    // ------------------------------------------------------------------------
    class noise_scoreboard;
        logic [1:0]  mode;
        logic [15:0] gain;
        longint      sections[6];
        longint      delay_term;
        longint      brown_acc;
        bit          playing;
        longint      pole_k[6];
        longint      feed_k[6];
        logic signed [SW-1:0] expected_noise[$];
        int          fail_count;

        function new();
            pole_k = '{16758090, 16665144, 16257122, 14537458, 9227469, -12777528};
            feed_k = '{931436, 1259565, 2581208, 5209084, 8941454, -283501};
            fail_count = 0;
            mode = cns_pkg::MODE_WHITE;
            gain = '0;
            delay_term = 0;
            brown_acc = 0;
            playing = 1'b0;
            foreach (sections[k])
                sections[k] = 0;
        endfunction

        function void report(string msg);
            fail_count++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        // q1.24 coefficient times value, rounded half up, floor shift
        function longint coef_mul(longint c, longint x);
            return (c * x + 64'sd8388608) >>> 24;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int pending();
            return expected_noise.size();
        endfunction

        // accepted request: update state, queue the result it causes
        function void note_request(logic [1:0] cmd, logic signed [SW-1:0] ws);
            longint w;
            longint colored;
            longint sum;
            longint g;
            longint r;
            w = ws;
            case (cmd)
                cns_pkg::CMD_TRIGGER: if (gain != 0) playing = 1'b1;
                cns_pkg::CMD_RELEASE: playing = 1'b0;
                cns_pkg::CMD_TICK:
                begin
                    if (!playing || gain == 0)
                    begin
                        expected_noise.push_back('0);
                    end
                    else
                    begin
                        colored = 0;
                        case (mode)
                            cns_pkg::MODE_WHITE: colored = w;
                            cns_pkg::MODE_PINK:
                            begin
                                sum = 0;
                                for (int k = 0; k < 6; k++)
                                begin
                                    sections[k] = clip(coef_mul(pole_k[k], sections[k])
                                                       + coef_mul(feed_k[k], w),
                                                       -64'sd2147483648, 64'sd2147483647);
                                    sum += sections[k];
                                end
                                sum += delay_term + coef_mul(8995943, w);
                                sum = clip(sum, -64'sd2147483648, 64'sd2147483647);
                                delay_term = coef_mul(1944916, w);
                                colored = coef_mul(1845494, sum);
                            end
                            cns_pkg::MODE_BROWN:
                            begin
                                brown_acc = clip(brown_acc + coef_mul(335544, w),
                                                 -64'sd8388608, 64'sd8388607);
                                colored = brown_acc;
                            end
                            default: colored = 0;
                        endcase
                        g = (gain > 16'd32768) ? 32768 : longint'(gain);
                        r = (colored * g + 64'sd16384) >>> 15;
                        r = clip(r, -64'sd8388608, 64'sd8388607);
                        expected_noise.push_back(r[SW-1:0]);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic signed [SW-1:0] got);
            logic signed [SW-1:0] want;
            if (expected_noise.size() == 0)
            begin
                report($sformatf("unexpected noise_sample %0d", got));
                return;
            end
            want = expected_noise.pop_front();
            if (got !== want)
                report($sformatf("noise_sample %0d, expected %0d", got, want));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // dut signals, every driven input known from time zero
    // ------------------------------------------------------------------------
    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic [1:0]           command      = cns_pkg::CMD_TICK;
    logic signed [SW-1:0] white_sample = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic signed [SW-1:0] noise_sample;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [2:0]           paddr        = '0;
    logic [31:0]          pwdata       = '0;
    logic [31:0]          prdata;
    logic                 pready;

    noise_scoreboard sb = new();
    int  cycle_count  = 0;
    int  sent_items   = 0;
    bit  busy_stretch = 1'b0;   // no idling on either side while set

    colored_noise_shaper_unit #(.SAMPLE_BITS(SW)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .white_sample (white_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .noise_sample (noise_sample),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // monitor: both handshakes sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request(command, white_sample);
            if (out_valid && !out_stall)
                sb.check_result(noise_sample);
        end
    end

    // result side back pressure, changes only at the falling edge
    always @(negedge clk)
    begin
        out_stall <= !busy_stretch && ($urandom_range(0, 99) < 19);
    end

    // ------------------------------------------------------------------------
    // request driver: optional idle cycles, then hold until accepted
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [1:0] cmd, input logic signed [SW-1:0] ws);
        while (!busy_stretch && $urandom_range(0, 99) < 19)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        command      <= cmd;
        white_sample <= ws;
        do
            @(posedge clk);
        while (in_stall);
        if (cmd != CMD_UNUSED)
            sent_items++;
    endtask

    // stop sending until every result is in, then let trailing work finish
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
            sb.report($sformatf("register at %0d reads %0h, expected %0h",
                                addr, prdata, want));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // only called once the block is idle
    task automatic configure(input logic [1:0] mode, input logic [15:0] gain);
        apb_write(ADDR_MODE, {30'd0, mode});
        sb.mode = mode;
        apb_write(ADDR_GAIN, {16'd0, gain});
        sb.gain = gain;
        apb_read_check(ADDR_MODE, {30'd0, mode});
        apb_read_check(ADDR_GAIN, {16'd0, gain});
    endtask

    // style 4 leans on full scale positive, style 5 on full scale negative
    function automatic logic signed [SW-1:0] pick_sample(input int style);
        int r;
        r = $urandom_range(0, 99);
        if (style == 4)
            return (r < 75) ? SAMPLE_MAX : SW'($urandom);
        if (style == 5)
            return (r < 75) ? SAMPLE_MIN : SW'($urandom);
        if (r < 80)
            return SW'($urandom);
        if (r < 90)
            return SW'($signed($urandom_range(0, 255)) - 128);
        if (r < 95)
            return SAMPLE_MAX;
        return SAMPLE_MIN;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int         phase;
        int         len;
        int         style;
        int         r;
        logic [1:0] mode;
        logic [15:0] gain;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset config: level zero, so everything is silent and trigger is refused
        send_request(cns_pkg::CMD_TICK, SAMPLE_MAX);
        send_request(cns_pkg::CMD_TRIGGER, SAMPLE_MIN);
        send_request(cns_pkg::CMD_TICK, SAMPLE_MIN);
        send_request(CMD_UNUSED, SAMPLE_MAX);
        send_request(cns_pkg::CMD_TICK, 24'sd1);
        settle();

        // white at unity level, both extremes, then release silences it
        configure(cns_pkg::MODE_WHITE, 16'd32768);
        send_request(cns_pkg::CMD_TICK, SAMPLE_MAX);
        send_request(cns_pkg::CMD_TRIGGER, '0);
        send_request(cns_pkg::CMD_TICK, SAMPLE_MAX);
        send_request(cns_pkg::CMD_TICK, SAMPLE_MIN);
        send_request(cns_pkg::CMD_TICK, -24'sd1);
        send_request(CMD_UNUSED, '0);
        send_request(cns_pkg::CMD_RELEASE, SAMPLE_MAX);
        send_request(cns_pkg::CMD_TICK, 24'sd5);
        send_request(cns_pkg::CMD_TRIGGER, '0);
        settle();

        // brown with the level above one, still playing across the write
        configure(cns_pkg::MODE_BROWN, 16'hFFFF);
        send_request(cns_pkg::CMD_TICK, SAMPLE_MAX);
        send_request(cns_pkg::CMD_TICK, SAMPLE_MAX);
        send_request(cns_pkg::CMD_TICK, SAMPLE_MIN);
        settle();

        // unused mode gives zero and leaves the filters alone
        configure(MODE_UNUSED, 16'd32768);
        send_request(cns_pkg::CMD_TICK, SAMPLE_MAX);
        settle();

        // pink at the smallest nonzero level
        configure(cns_pkg::MODE_PINK, 16'd1);
        send_request(cns_pkg::CMD_TICK, SAMPLE_MAX);
        send_request(cns_pkg::CMD_TICK, SAMPLE_MIN);
        send_request(cns_pkg::CMD_TICK, '0);
        settle();

        // random phases, each with its own mode, level and sample style
        phase = 0;
        while (sent_items < RANDOM_ITEMS + 20)
        begin
            phase++;
            if ($urandom_range(0, 9) == 0)
                mode = MODE_UNUSED;
            else
                mode = 2'($urandom_range(0, 2));
            case ($urandom_range(0, 9))
                0:       gain = 16'd0;
                1:       gain = 16'd1;
                2:       gain = 16'd32767;
                3, 4:    gain = 16'd32768;
                5:       gain = 16'hFFFF;
                default: gain = 16'($urandom_range(1, 65535));
            endcase
            settle();
            configure(mode, gain);
            busy_stretch = (phase == 3);
            style = $urandom_range(0, 5);
            len   = $urandom_range(30, 90);
            if ($urandom_range(0, 9) != 0)
                send_request(cns_pkg::CMD_TRIGGER, SW'($urandom));
            for (int i = 0; i < len; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 88)
                    send_request(cns_pkg::CMD_TICK, pick_sample(style));
                else if (r < 93)
                    send_request(cns_pkg::CMD_RELEASE, SW'($urandom));
                else if (r < 97)
                    send_request(cns_pkg::CMD_TRIGGER, SW'($urandom));
                else
                    send_request(CMD_UNUSED, SW'($urandom));
                // sender holds off mid phase until the result side has caught up
                if (phase == 2 && i == len / 2)
                    settle();
            end
            busy_stretch = 1'b0;
        end

        settle();
        if (sb.fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
